[src/stot_pkg.sv]
// Package for the server time offset tracker: beat types, state record,
// adjustment codes, configuration indexes and tracking limits.
// No dependencies; every other file imports it.
package stot_pkg;

	localparam int unsigned TIME_W = 31;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned NUDGE_W = 11;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [WORD_W-1:0] RESET_LIMIT = 32'd500;
	localparam logic [WORD_W-1:0] FAST_LIMIT = 32'd100;
	localparam logic signed [NUDGE_W-1:0] NUDGE_LIMIT = 11'sd30;
	localparam logic [WORD_W-1:0] EXTRAP_MARGIN = 32'd5;
	localparam logic [WORD_W-1:0] DRIFT_FWD_STEP = 32'd1;
	localparam logic [WORD_W-1:0] DRIFT_BACK_STEP = 32'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_TIME_NUDGE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DRIFT = 1'd1;

	typedef enum logic {
		CMD_SNAPSHOT = 1'b0,
		CMD_FRAME    = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ADJ_NONE       = 3'd0,
		ADJ_RESET      = 3'd1,
		ADJ_FAST_HALVE = 3'd2,
		ADJ_DRIFT_FWD  = 3'd3,
		ADJ_DRIFT_BACK = 3'd4
	} adj_kind_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [TIME_W-1:0] local_time;
		logic [TIME_W-1:0] snap_time;
		logic              snap_inactive;
	} in_beat_t;

	typedef struct packed {
		logic [WORD_W-1:0] est_remote_time;
		logic [WORD_W-1:0] offset;
		adj_kind_t         adjust_kind;
		logic              extrapolating;
		logic              is_active;
		logic              backward_error;
	} out_beat_t;

	// Tracker state; snapshot times are never wider than the input field.
	typedef struct packed {
		logic [WORD_W-1:0] offset;
		logic [WORD_W-1:0] last_est;
		logic [TIME_W-1:0] latest_snap;
		logic              latest_inactive;
		logic [TIME_W-1:0] prev_frame_snap;
		logic              pending;
		logic              extrap;
		logic              active;
	} track_state_t;

	// Settings seen by the datapath.
	typedef struct packed {
		logic [NUDGE_W-1:0] nudge;
		logic               drift_en;
	} track_cfg_t;

endpackage

[src/stot_cfg.sv]
// Configuration registers of the offset tracker: nudge (stored already
// clamped to the nudge limit) and slow drift enable. Depends on stot_pkg.
module stot_cfg
	import stot_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [NUDGE_W-1:0]   cfg_data,
	output track_cfg_t           cfg
);

	logic [NUDGE_W-1:0] nudge_q;
	logic               drift_en_q;
	logic [NUDGE_W-1:0] nudge_clamped;

	always_comb begin
		priority if ($signed(cfg_data) < -NUDGE_LIMIT) begin
			nudge_clamped = -NUDGE_LIMIT;
		end else if ($signed(cfg_data) > NUDGE_LIMIT) begin
			nudge_clamped = NUDGE_LIMIT;
		end else begin
			nudge_clamped = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nudge_q    <= '0;
			drift_en_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TIME_NUDGE: nudge_q    <= nudge_clamped;
				CFG_SLOW_DRIFT: drift_en_q <= cfg_data[0];
				default:        drift_en_q <= drift_en_q;
			endcase
		end
	end

	assign cfg.nudge    = nudge_q;
	assign cfg.drift_en = drift_en_q;

endmodule

[src/stot_update.sv]
// Single-pass next-state and result logic for one beat of the offset
// tracker: activation, estimate, extrapolation flag and offset adjustment.
// Depends on stot_pkg.
module stot_update
	import stot_pkg::*;
(
	input  in_beat_t     item,
	input  track_state_t st,
	input  track_cfg_t   cfg,
	output track_state_t st_nxt,
	output out_beat_t    res
);

	logic [WORD_W-1:0] snap;
	logic [WORD_W-1:0] local_t;
	logic [WORD_W-1:0] new_delta;
	logic [WORD_W-1:0] base;
	logic [WORD_W-1:0] est;
	logic [WORD_W-1:0] diff;
	logic [WORD_W-1:0] mag;
	logic [WORD_W:0]   sum;
	logic              pend_adj;

	assign snap      = {1'b0, st.latest_snap};
	assign local_t   = {1'b0, item.local_time};
	assign new_delta = snap - local_t;

	always_comb begin
		st_nxt   = st;
		res      = '0;
		base     = '0;
		est      = '0;
		diff     = '0;
		mag      = '0;
		sum      = '0;
		pend_adj = 1'b0;

		unique case (item.cmd)
			CMD_SNAPSHOT: begin
				st_nxt.latest_snap     = item.snap_time;
				st_nxt.latest_inactive = item.snap_inactive;
				st_nxt.pending         = 1'b1;
			end
			CMD_FRAME: begin
				// Activate on the first pending snapshot that is not inactive.
				pend_adj = st.pending && st.active;
				if (!st.active && st.pending) begin
					st_nxt.pending = 1'b0;
					if (!st.latest_inactive) begin
						st_nxt.active   = 1'b1;
						st_nxt.offset   = new_delta;
						st_nxt.last_est = snap;
					end
				end

				if (!st_nxt.active) begin
					res.est_remote_time = st_nxt.last_est;
					res.offset          = st_nxt.offset;
					res.adjust_kind     = ADJ_NONE;
				end else begin
					res.is_active          = 1'b1;
					res.backward_error     = st.latest_snap < st.prev_frame_snap;
					st_nxt.prev_frame_snap = st.latest_snap;

					// Monotonic estimate: never step below the last one, except on an offset reset.
					base = local_t + st_nxt.offset;
					est  = base - {{(WORD_W-NUDGE_W){cfg.nudge[NUDGE_W-1]}}, cfg.nudge};
					if ($signed(est) < $signed(st_nxt.last_est)) begin
						est = st_nxt.last_est;
					end
					st_nxt.last_est = est;

					if ($signed(base) >= $signed(snap - EXTRAP_MARGIN)) begin
						st_nxt.extrap     = 1'b1;
						res.extrapolating = 1'b1;
					end

					res.adjust_kind = ADJ_NONE;
					if (pend_adj) begin
						st_nxt.pending = 1'b0;
						diff = new_delta - st.offset;
						mag  = diff[WORD_W-1] ? (~diff + 1'b1) : diff;
						sum  = {st.offset[WORD_W-1], st.offset}
							+ {new_delta[WORD_W-1], new_delta};
						priority if (mag > RESET_LIMIT) begin
							st_nxt.offset   = new_delta;
							st_nxt.last_est = snap;
							est             = snap;
							res.adjust_kind = ADJ_RESET;
						end else if (mag > FAST_LIMIT) begin
							// Floor of the exact sum over two.
							st_nxt.offset   = sum[WORD_W:1];
							res.adjust_kind = ADJ_FAST_HALVE;
						end else if (cfg.drift_en) begin
							if (st_nxt.extrap) begin
								st_nxt.extrap   = 1'b0;
								st_nxt.offset   = st.offset - DRIFT_BACK_STEP;
								res.adjust_kind = ADJ_DRIFT_BACK;
							end else begin
								st_nxt.offset   = st.offset + DRIFT_FWD_STEP;
								res.adjust_kind = ADJ_DRIFT_FWD;
							end
						end
					end
					res.est_remote_time = est;
					res.offset          = st_nxt.offset;
				end
			end
			default: st_nxt = st;
		endcase
	end

endmodule

[src/server_time_offset_tracker_core.sv]
// Top level of the server time offset tracker: input register, tracker
// state, result register and handshakes. Depends on stot_pkg, stot_cfg and
// stot_update.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one beat per
//   command. A snapshot beat latches a remote time and yields no result; a
//   frame beat yields exactly one result beat on the output channel
//   (out_valid / out_stall / out_data).
//   Path: an accepted frame beat goes into the input register, then, unless
//   the output stalls, into the result register for the receiver to take.
//   Throughput: one beat per cycle unless stalled; the whole update for a
//   beat is done in one pass between the input register and the result
//   register, and the tracker state is written on that same edge so the
//   next beat sees it.
//   Stall: while out_stall holds a result in the output register, a frame
//   beat waits in the input register and in_stall rises; snapshot beats keep
//   flowing since they produce nothing. One more frame beat is taken while a
//   result waits, so the two sides are parted by the result register.
//   Reset (arst_n low): both registers empty, tracker state cleared,
//   nudge 0 and slow drift enabled.
//   Configuration: write cfg_we / cfg_index / cfg_data only while idle.
module server_time_offset_tracker_core
	import stot_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_beat_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_beat_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [NUDGE_W-1:0]   cfg_data
);

	track_cfg_t   cfg;
	track_state_t st_q;
	track_state_t st_nxt;
	out_beat_t    res;

	in_beat_t  item_s1;
	logic      valid_s1;
	out_beat_t result_s2;
	logic      valid_s2;

	logic in_fire;
	logic adv;
	logic frame_adv;

	stot_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	stot_update u_update (
		.item   (item_s1),
		.st     (st_q),
		.cfg    (cfg),
		.st_nxt (st_nxt),
		.res    (res)
	);

	// Advance the held beat when it needs no result slot or the slot frees.
	assign adv       = valid_s1 && (item_s1.cmd == CMD_SNAPSHOT || !valid_s2 || !out_stall);
	assign frame_adv = adv && item_s1.cmd == CMD_FRAME;
	assign in_stall  = valid_s1 && !adv;
	assign in_fire   = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= in_data;
		end
	end

	// Tracker state: update on every beat that leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	// Result register: load on a frame beat, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (frame_adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_adv) begin
			result_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	// Once active the tracker never drops back.
	a_active_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.active |=> st_q.active)
		else $error("tracker left the active state");

	// A result marked active implies the state is active.
	a_result_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_active |-> st_q.active)
		else $error("active result while tracker inactive");

	// Results before activation carry no adjustment or flags.
	a_inactive_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.is_active |->
			out_data.adjust_kind == ADJ_NONE && !out_data.extrapolating
			&& !out_data.backward_error)
		else $error("inactive result carries flags");

	// Estimate never moves backward except on an offset reset.
	a_est_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		frame_adv && st_q.active && res.adjust_kind != ADJ_RESET |->
			$signed(res.est_remote_time) >= $signed(st_q.last_est))
		else $error("estimate moved backward");

	// A snapshot beat never holds the input register.
	a_snap_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.cmd == CMD_SNAPSHOT |-> !in_stall)
		else $error("snapshot beat stalled");

endmodule

[tb/tb.sv]
// Testbench for server_time_offset_tracker_core: a directed table, then
// random snapshot/frame streams under several nudge and drift settings.
// Depends on stot_pkg and the core RTL only.
module tb
	import stot_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// Ports of the block; every input starts at a known value.
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_beat_t             in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_beat_t            out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [NUDGE_W-1:0]   cfg_data = '0;

	server_time_offset_tracker_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// One row of the directed table: the beat, and for rows whose result can
	// be read off directly, the result typed in.
	typedef struct {
		in_beat_t  beat;
		bit        typed;
		out_beat_t want;
	} step_row_t;

	localparam int PHASES = 8;
	localparam int BEATS_PER_PHASE = 190;

	// Our own copy of the tracker state and settings.
	logic [WORD_W-1:0]        trk_offset;
	logic [WORD_W-1:0]        trk_last_est;
	logic [TIME_W-1:0]        trk_snap;
	logic                     trk_snap_inactive;
	logic [TIME_W-1:0]        trk_prev_snap;
	logic                     trk_pending;
	logic                     trk_extrap;
	logic                     trk_active;
	logic signed [NUDGE_W-1:0] nudge_set;
	logic                     drift_set;

	out_beat_t   expected_results[$];
	step_row_t   directed_rows[$];
	int          fault_count = 0;
	int          send_calm = 0;
	int          take_calm = 0;
	logic [TIME_W-1:0] cruise_local;
	logic [WORD_W-1:0] cruise_off;

	initial begin
		forever #10 clk = ~clk;
	end

	// Run ends here no matter what; far beyond the slowest correct run.
	initial begin
		#20_000_000;
		$display("server_time_offset_tracker_core test failed");
		$finish;
	end

	// Draw a wait count of 0..19, with occasional stretches of no waiting.
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			calm = $urandom_range(20, 60);
		return $urandom_range(0, 19);
	endfunction

	function automatic in_beat_t frame_at(logic [TIME_W-1:0] lt);
		in_beat_t b;
		b = '0;
		b.cmd = CMD_FRAME;
		b.local_time = lt;
		return b;
	endfunction

	function automatic in_beat_t snap_at(logic [TIME_W-1:0] st, logic inact);
		in_beat_t b;
		b = '0;
		b.cmd = CMD_SNAPSHOT;
		b.snap_time = st;
		b.snap_inactive = inact;
		return b;
	endfunction

	function automatic void add_row(in_beat_t b, bit typed = 1'b0, out_beat_t want = '0);
		step_row_t r;
		r.beat = b;
		r.typed = typed;
		r.want = want;
		directed_rows.push_back(r);
	endfunction

	// Advance the tracker by one beat; a frame yields the estimate it computes.
	function automatic void track_beat(input in_beat_t b, output bit emits,
			output out_beat_t res);
		logic [WORD_W-1:0] snap, base, est, new_delta, diff, mag;
		int tn;
		longint sum;
		logic extrap_now, backward;
		adj_kind_t adj;

		res = '0;
		emits = 1'b0;
		// A snapshot only latches the time and marks it pending.
		if (b.cmd == CMD_SNAPSHOT) begin
			trk_snap = b.snap_time;
			trk_snap_inactive = b.snap_inactive;
			trk_pending = 1'b1;
			return;
		end
		emits = 1'b1;
		snap = {1'b0, trk_snap};
		// Until active, only an active pending snapshot can start tracking.
		if (!trk_active) begin
			if (trk_pending) begin
				trk_pending = 1'b0;
				if (!trk_snap_inactive) begin
					trk_active = 1'b1;
					trk_offset = snap - {1'b0, b.local_time};
					trk_last_est = snap;
				end
			end
			if (!trk_active) begin
				res.est_remote_time = trk_last_est;
				res.offset = trk_offset;
				res.adjust_kind = ADJ_NONE;
				return;
			end
		end

		backward = trk_snap < trk_prev_snap;
		trk_prev_snap = trk_snap;

		tn = int'(nudge_set);
		if (tn < -int'(NUDGE_LIMIT))
			tn = -int'(NUDGE_LIMIT);
		else if (tn > int'(NUDGE_LIMIT))
			tn = int'(NUDGE_LIMIT);

		// Keep the estimate monotonic.
		base = {1'b0, b.local_time} + trk_offset;
		est = base - tn;
		if ($signed(est) < $signed(trk_last_est))
			est = trk_last_est;
		trk_last_est = est;

		extrap_now = 1'b0;
		if ($signed(base) >= $signed(snap - EXTRAP_MARGIN)) begin
			trk_extrap = 1'b1;
			extrap_now = 1'b1;
		end

		adj = ADJ_NONE;
		if (trk_pending) begin
			new_delta = snap - {1'b0, b.local_time};
			diff = new_delta - trk_offset;
			mag = diff[WORD_W-1] ? (~diff + 1'b1) : diff;
			trk_pending = 1'b0;
			if (mag > RESET_LIMIT) begin
				trk_offset = new_delta;
				trk_last_est = snap;
				est = snap;
				adj = ADJ_RESET;
			end else if (mag > FAST_LIMIT) begin
				// Floor of the exact sum over two.
				sum = $signed(trk_offset);
				sum += $signed(new_delta);
				sum = sum >>> 1;
				trk_offset = sum[WORD_W-1:0];
				adj = ADJ_FAST_HALVE;
			end else if (drift_set) begin
				if (trk_extrap) begin
					trk_extrap = 1'b0;
					trk_offset -= DRIFT_BACK_STEP;
					adj = ADJ_DRIFT_BACK;
				end else begin
					trk_offset += DRIFT_FWD_STEP;
					adj = ADJ_DRIFT_FWD;
				end
			end
		end

		res.est_remote_time = est;
		res.offset = trk_offset;
		res.adjust_kind = adj;
		res.extrapolating = extrap_now;
		res.is_active = 1'b1;
		res.backward_error = backward;
	endfunction

	// Random beat: mostly a plausible stream of frames and snapshots that
	// follow a hidden true offset, with noise mixed in.
	function automatic in_beat_t next_beat();
		in_beat_t b;
		int pick, jit;
		logic [WORD_W-1:0] s;

		b = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 8)
			return b;
		if (pick < 58) begin
			cruise_local += TIME_W'($urandom_range(0, 40));
			b.cmd = CMD_FRAME;
			b.local_time = cruise_local;
			return b;
		end
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			jit = $urandom_range(0, 16);
			jit -= 8;
		end else if (pick < 75) begin
			jit = $urandom_range(90, 520);
			if ($urandom_range(0, 1) == 1)
				jit = -jit;
		end else if (pick < 85) begin
			jit = $urandom_range(400, 5000);
			if ($urandom_range(0, 1) == 1)
				jit = -jit;
		end else if (pick < 90) begin
			// Jump the remote clock somewhere else.
			cruise_off = $urandom;
			jit = 0;
		end else begin
			jit = $urandom_range(0, 30);
		end
		s = {1'b0, cruise_local} + cruise_off + jit;
		b.cmd = CMD_SNAPSHOT;
		b.snap_time = s[TIME_W-1:0];
		b.snap_inactive = ($urandom_range(0, 9) == 0);
		return b;
	endfunction

	function automatic void note_mismatch(string field, longint want_v, longint got_v);
		fault_count++;
		$display("%0t: %s expected %0d got %0d", $time, field, want_v, got_v);
	endfunction

	// Compare one result beat with the oldest expectation.
	task automatic check_result(input out_beat_t got);
		out_beat_t want;
		if (expected_results.size() == 0) begin
			fault_count++;
			$display("%0t: unexpected result beat est=%0d offset=%0d", $time,
				$signed(got.est_remote_time), $signed(got.offset));
			return;
		end
		want = expected_results.pop_front();
		if (got.est_remote_time !== want.est_remote_time)
			note_mismatch("est_remote_time", $signed(want.est_remote_time),
				$signed(got.est_remote_time));
		if (got.offset !== want.offset)
			note_mismatch("offset", $signed(want.offset), $signed(got.offset));
		if (got.adjust_kind !== want.adjust_kind)
			note_mismatch("adjust_kind", want.adjust_kind, got.adjust_kind);
		if (got.extrapolating !== want.extrapolating)
			note_mismatch("extrapolating", want.extrapolating, got.extrapolating);
		if (got.is_active !== want.is_active)
			note_mismatch("is_active", want.is_active, got.is_active);
		if (got.backward_error !== want.backward_error)
			note_mismatch("backward_error", want.backward_error, got.backward_error);
	endtask

	// Offer one beat after a random gap, hold it until taken, then predict.
	task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t want);
		int gap;
		bit emits;
		out_beat_t guess;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (in_stall);
		track_beat(b, emits, guess);
		if (emits)
			expected_results.push_back(typed ? want : guess);
	endtask

	// Drop valid and wait until every result is back and the block has
	// finished any snapshot still in flight.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write both registers on back-to-back edges; the block must be idle.
	task automatic apply_settings(input logic [NUDGE_W-1:0] n, input logic d);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TIME_NUDGE;
		cfg_data <= n;
		@(posedge clk);
		cfg_index <= CFG_SLOW_DRIFT;
		cfg_data <= NUDGE_W'(d);
		@(posedge clk);
		cfg_we <= 1'b0;
		nudge_set = n;
		drift_set = d;
	endtask

	// Receiver: stall a random number of cycles, then take one result beat.
	initial begin
		int hold;
		while (!arst_n) @(posedge clk);
		forever begin
			hold = draw_wait(take_calm);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			check_result(out_data);
		end
	end

	// Stimulus: reset, directed table, then random phases.
	initial begin
		logic signed [NUDGE_W-1:0] nudge_plan[PHASES];
		logic drift_plan[PHASES];
		logic [NUDGE_W-1:0] n;
		logic d;

		nudge_plan = '{11'sd900, -11'sd900, -11'sd1024, 11'sd1023, 11'sd30, -11'sd31,
			11'sd0, 11'sd0};
		drift_plan = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

		// Match the block's state after reset.
		trk_offset = '0;
		trk_last_est = '0;
		trk_snap = '0;
		trk_snap_inactive = 1'b0;
		trk_prev_snap = '0;
		trk_pending = 1'b0;
		trk_extrap = 1'b0;
		trk_active = 1'b0;
		nudge_set = '0;
		drift_set = 1'b1;

		// Frame before any snapshot, then an inactive snapshot that is
		// consumed without starting tracking.
		add_row(frame_at(31'd7), 1'b1, '{32'd0, 32'd0, ADJ_NONE, 1'b0, 1'b0, 1'b0});
		add_row(snap_at(31'd123, 1'b1));
		add_row(frame_at(31'd50), 1'b1, '{32'd0, 32'd0, ADJ_NONE, 1'b0, 1'b0, 1'b0});
		// Two snapshots back to back: the later, active one wins and starts
		// tracking with offset 600.
		add_row(snap_at(31'd900, 1'b1));
		add_row(snap_at(31'd1000, 1'b0));
		add_row(frame_at(31'd400), 1'b1,
			'{32'd1000, 32'd600, ADJ_NONE, 1'b1, 1'b1, 1'b0});
		add_row(frame_at(31'd410), 1'b1,
			'{32'd1010, 32'd600, ADJ_NONE, 1'b1, 1'b1, 1'b0});
		// Small error while extrapolating, then fast halving, then drift.
		add_row(snap_at(31'd2000, 1'b0));
		add_row(frame_at(31'd1395));
		add_row(snap_at(31'd3000, 1'b0));
		add_row(frame_at(31'd2000));
		add_row(snap_at(31'd4000, 1'b0));
		add_row(frame_at(31'd3300));
		// Field extremes: the largest snapshot at local zero forces a reset,
		// then a snapshot at zero runs backward.
		add_row(snap_at(31'h7FFF_FFFF, 1'b0));
		add_row(frame_at(31'd0));
		add_row(snap_at(31'd0, 1'b1));
		add_row(frame_at(31'h7FFF_FFFF));
		add_row(frame_at(31'd0));
		add_row(snap_at(31'h7FFF_FFFF, 1'b1));
		add_row(frame_at(31'h7FFF_FFFF));
		add_row(frame_at(31'h7FFF_FFFF));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

		// Each phase waits for the block to go idle before new settings.
		for (int p = 0; p < PHASES; p++) begin
			drain();
			n = nudge_plan[p];
			d = drift_plan[p];
			if (p == PHASES - 1) begin
				n = NUDGE_W'($urandom);
				d = 1'($urandom_range(0, 1));
			end
			apply_settings(n, d);
			cruise_local = (p == 2) ? 31'h7FFF_F000 : TIME_W'($urandom);
			cruise_off = $urandom;
			for (int k = 0; k < BEATS_PER_PHASE; k++)
				send_beat(next_beat(), 1'b0, '0);
		end

		drain();
		repeat (10) @(posedge clk);
		if (fault_count == 0)
			$display("server_time_offset_tracker_core test passed");
		else
			$display("server_time_offset_tracker_core test failed");
		$finish;
	end

endmodule
